@@ design/lsau_pkg.sv @@
// lsau_pkg: shared types and constants for the load/store address unit
// no dependencies
`timescale 1ns / 1ps

package lsau_pkg;

    // request types on the input tuser
    localparam logic [1:0] REQ_INSTR     = 2'd0;
    localparam logic [1:0] REQ_LOAD_DATA = 2'd1;
    localparam logic [1:0] REQ_EXT_WRITE = 2'd2;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned REG_W    = 4;
    localparam int unsigned SHAMT_W  = 5;
    localparam int unsigned IMM_W    = 12;
    localparam int unsigned S_TDATA_W = 72;
    localparam int unsigned M_TDATA_W = 104;

    localparam logic [REG_W-1:0]  PC_IDX    = 4'hF;
    localparam logic [1:0]        XFER_OP   = 2'b01;
    localparam logic [DATA_W-1:0] PC_STEP   = 32'd4;
    localparam logic [DATA_W-1:0] PC_AHEAD  = 32'd8;

    typedef enum logic [1:0] {
        CLS_XFER,
        CLS_LOAD_DATA,
        CLS_EXT_WRITE,
        CLS_IGNORE
    } item_class_t;

    typedef enum logic [2:0] {
        KIND_READ        = 3'd0,
        KIND_WRITE       = 3'd1,
        KIND_LOAD_DONE   = 3'd2,
        KIND_IGNORED     = 3'd3,
        KIND_REG_WRITTEN = 3'd4
    } result_kind_t;

    typedef struct packed {
        item_class_t         cls;
        logic                load;
        logic                wback;
        logic                byte_sel;
        logic                up;
        logic                pre;
        logic                reg_off;
        logic [REG_W-1:0]    rn;
        logic [REG_W-1:0]    rd;
        logic [REG_W-1:0]    rm;
        logic [SHAMT_W-1:0]  shamt;
        logic [IMM_W-1:0]    imm;
        logic [DATA_W-1:0]   data;
        logic [REG_W-1:0]    idx;
    } item_t;

    typedef struct packed {
        logic             load_pending;
        logic             ram_we;
        logic [REG_W-1:0] ram_waddr;
    } back_status_t;

endpackage

@@ design/lsau_ram.sv @@
// lsau_ram: generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module lsau_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

@@ design/lsau_front.sv @@
// lsau_front: accepts input items and classifies them into queue entries
// depends on lsau_pkg
`timescale 1ns / 1ps

module lsau_front (
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lsau_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [1:0]                      s_tuser,
    input  logic                            full,
    output logic                            push,
    output lsau_pkg::item_t                 item
);

    logic [lsau_pkg::DATA_W-1:0] iw;

    assign iw       = s_tdata[31:0];
    assign s_tready = !full;
    assign push     = s_tvalid && !full;

    always_comb
    begin
        item.load     = iw[20];
        item.wback    = iw[21];
        item.byte_sel = iw[22];
        item.up       = iw[23];
        item.pre      = iw[24];
        item.reg_off  = iw[25];
        item.rn       = iw[19:16];
        item.rd       = iw[15:12];
        item.rm       = iw[3:0];
        item.shamt    = iw[11:7];
        item.imm      = iw[11:0];
        item.data     = s_tdata[63:32];
        item.idx      = s_tdata[67:64];
        case (s_tuser)
            lsau_pkg::REQ_INSTR:
            begin
                item.cls = (iw[27:26] == lsau_pkg::XFER_OP) ? lsau_pkg::CLS_XFER
                                                            : lsau_pkg::CLS_IGNORE;
            end
            lsau_pkg::REQ_LOAD_DATA: item.cls = lsau_pkg::CLS_LOAD_DATA;
            lsau_pkg::REQ_EXT_WRITE: item.cls = lsau_pkg::CLS_EXT_WRITE;
            default:                 item.cls = lsau_pkg::CLS_IGNORE;
        endcase
    end

endmodule

@@ design/lsau_queue.sv @@
// lsau_queue: short fifo of classified items between front and back
// depends on lsau_pkg
`timescale 1ns / 1ps

module lsau_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  lsau_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output lsau_pkg::item_t head_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    lsau_pkg::item_t  store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_item  = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ design/lsau_back.sv @@
// lsau_back: register file read, execute stage, load tracking and output register
// depends on lsau_pkg and lsau_ram
`timescale 1ns / 1ps

module lsau_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            head_valid,
    input  lsau_pkg::item_t                 head_item,
    output logic                            pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lsau_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [2:0]                      m_tuser,
    output lsau_pkg::back_status_t          status
);

    localparam int unsigned W  = lsau_pkg::DATA_W;
    localparam int unsigned RW = lsau_pkg::REG_W;
    localparam int unsigned NREG = 16;

    // execute stage
    logic            e_valid_reg, e_valid_next;
    lsau_pkg::item_t e_item_reg;
    logic            e_adv;
    logic [W-1:0]    q_rm, q_rn, q_rd;

    // architectural state
    logic [W-1:0]    pc_reg, pc_next;
    logic [NREG-1:0] written_reg, written_next;
    logic            pend_reg, pend_next;
    logic [RW-1:0]   target_reg, target_next;
    logic            isbyte_reg, isbyte_next;
    logic            ovr_reg, ovr_next;

    // last register file write, forwarded over the read latency
    logic            fwd_en_reg;
    logic [RW-1:0]   fwd_addr_reg;
    logic [W-1:0]    fwd_data_reg;

    // output register
    logic                   out_valid_reg, out_valid_next;
    lsau_pkg::result_kind_t out_kind_reg, kind_next;
    logic [W-1:0]           out_addr_reg, addr_next;
    logic [W-1:0]           out_wdata_reg, wdata_next;
    logic                   out_byte_reg, byte_next;
    logic [W-1:0]           out_pc_reg;

    logic            we;
    logic [RW-1:0]   waddr;
    logic [W-1:0]    wval;

    logic [W-1:0]    rm_val, rn_val, rd_val;
    logic [W-1:0]    offset, newbase, eff_addr, ld_val;
    logic            wb;

    assign e_adv = e_valid_reg && (!out_valid_reg || m_tready);
    assign pop   = head_valid && (!e_valid_reg || e_adv);

    lsau_ram #(.WIDTH(W), .DEPTH(NREG)) u_ram_rm (
        .clk(clk), .we(we && e_adv), .waddr(waddr), .wdata(wval),
        .re(pop), .raddr(head_item.rm), .rdata(q_rm)
    );

    lsau_ram #(.WIDTH(W), .DEPTH(NREG)) u_ram_rn (
        .clk(clk), .we(we && e_adv), .waddr(waddr), .wdata(wval),
        .re(pop), .raddr(head_item.rn), .rdata(q_rn)
    );

    lsau_ram #(.WIDTH(W), .DEPTH(NREG)) u_ram_rd (
        .clk(clk), .we(we && e_adv), .waddr(waddr), .wdata(wval),
        .re(pop), .raddr(head_item.rd), .rdata(q_rd)
    );

    function automatic logic [W-1:0] reg_value(
        input logic [RW-1:0]   a,
        input logic [W-1:0]    q,
        input logic [W-1:0]    pc,
        input logic            f_en,
        input logic [RW-1:0]   f_addr,
        input logic [W-1:0]    f_data,
        input logic [NREG-1:0] written
    );
        logic [W-1:0] v;
        if (a == lsau_pkg::PC_IDX)
        begin
            v = pc;
        end
        else if (f_en && f_addr == a)
        begin
            v = f_data;
        end
        else if (written[a])
        begin
            v = q;
        end
        else
        begin
            v = '0;
        end
        return v;
    endfunction

    always_comb
    begin
        rm_val = reg_value(e_item_reg.rm, q_rm, pc_reg, fwd_en_reg, fwd_addr_reg,
                           fwd_data_reg, written_reg);
        rn_val = reg_value(e_item_reg.rn, q_rn, pc_reg, fwd_en_reg, fwd_addr_reg,
                           fwd_data_reg, written_reg);
        rd_val = reg_value(e_item_reg.rd, q_rd, pc_reg, fwd_en_reg, fwd_addr_reg,
                           fwd_data_reg, written_reg);

        offset   = e_item_reg.reg_off ? (rm_val << e_item_reg.shamt)
                                      : {{(W - lsau_pkg::IMM_W){1'b0}}, e_item_reg.imm};
        newbase  = e_item_reg.up ? (rn_val + offset) : (rn_val - offset);
        eff_addr = e_item_reg.pre ? newbase : rn_val;
        wb       = e_item_reg.pre ? e_item_reg.wback : 1'b1;
        // pc as base reads two instructions ahead
        if (e_item_reg.rn == lsau_pkg::PC_IDX)
        begin
            eff_addr = eff_addr + lsau_pkg::PC_AHEAD;
            newbase  = newbase + lsau_pkg::PC_AHEAD;
        end
        ld_val = isbyte_reg ? {{(W - 8){1'b0}}, e_item_reg.data[7:0]} : e_item_reg.data;

        kind_next   = lsau_pkg::KIND_IGNORED;
        addr_next   = '0;
        wdata_next  = '0;
        byte_next   = 1'b0;
        pc_next     = pc_reg;
        we          = 1'b0;
        waddr       = e_item_reg.rn;
        wval        = newbase;
        pend_next   = pend_reg;
        target_next = target_reg;
        isbyte_next = isbyte_reg;
        ovr_next    = ovr_reg;

        case (e_item_reg.cls)
            lsau_pkg::CLS_XFER:
            begin
                if (!pend_reg)
                begin
                    addr_next = eff_addr;
                    byte_next = e_item_reg.byte_sel;
                    pc_next   = pc_reg + lsau_pkg::PC_STEP;
                    if (wb)
                    begin
                        if (e_item_reg.rn == lsau_pkg::PC_IDX)
                        begin
                            pc_next = newbase + lsau_pkg::PC_STEP;
                        end
                        else
                        begin
                            we = 1'b1;
                        end
                    end
                    if (e_item_reg.load)
                    begin
                        kind_next   = lsau_pkg::KIND_READ;
                        pend_next   = 1'b1;
                        target_next = e_item_reg.rd;
                        isbyte_next = e_item_reg.byte_sel;
                        ovr_next    = wb && (e_item_reg.rn == e_item_reg.rd);
                    end
                    else
                    begin
                        kind_next  = lsau_pkg::KIND_WRITE;
                        wdata_next = e_item_reg.byte_sel ? {{(W - 8){1'b0}}, rd_val[7:0]}
                                                         : rd_val;
                    end
                end
            end
            lsau_pkg::CLS_LOAD_DATA:
            begin
                if (pend_reg)
                begin
                    kind_next = lsau_pkg::KIND_LOAD_DONE;
                    byte_next = isbyte_reg;
                    pend_next = 1'b0;
                    ovr_next  = 1'b0;
                    waddr     = target_reg;
                    wval      = ld_val;
                    if (!ovr_reg)
                    begin
                        if (target_reg == lsau_pkg::PC_IDX)
                        begin
                            pc_next = ld_val;
                        end
                        else
                        begin
                            we = 1'b1;
                        end
                    end
                end
            end
            lsau_pkg::CLS_EXT_WRITE:
            begin
                kind_next = lsau_pkg::KIND_REG_WRITTEN;
                waddr     = e_item_reg.idx;
                wval      = e_item_reg.data;
                if (e_item_reg.idx == lsau_pkg::PC_IDX)
                begin
                    pc_next = e_item_reg.data;
                end
                else
                begin
                    we = 1'b1;
                end
                if (pend_reg && e_item_reg.idx == target_reg)
                begin
                    ovr_next = 1'b1;
                end
            end
            default: ;
        endcase

        written_next = written_reg;
        if (we)
        begin
            written_next[waddr] = 1'b1;
        end

        e_valid_next = pop ? 1'b1 : (e_adv ? 1'b0 : e_valid_reg);
        out_valid_next = e_adv ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            pc_reg        <= '0;
            written_reg   <= '0;
            pend_reg      <= 1'b0;
            target_reg    <= '0;
            isbyte_reg    <= 1'b0;
            ovr_reg       <= 1'b0;
            fwd_en_reg    <= 1'b0;
        end
        else
        begin
            e_valid_reg   <= e_valid_next;
            out_valid_reg <= out_valid_next;
            if (e_adv)
            begin
                pc_reg      <= pc_next;
                written_reg <= written_next;
                pend_reg    <= pend_next;
                target_reg  <= target_next;
                isbyte_reg  <= isbyte_next;
                ovr_reg     <= ovr_next;
                fwd_en_reg  <= we;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            e_item_reg <= head_item;
        end
        if (e_adv)
        begin
            fwd_addr_reg  <= waddr;
            fwd_data_reg  <= wval;
            out_kind_reg  <= kind_next;
            out_addr_reg  <= addr_next;
            out_wdata_reg <= wdata_next;
            out_byte_reg  <= byte_next;
            out_pc_reg    <= pc_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {7'b0, out_pc_reg, out_byte_reg, out_wdata_reg, out_addr_reg};

    assign status.load_pending = pend_reg;
    assign status.ram_we       = we && e_adv;
    assign status.ram_waddr    = waddr;

endmodule

@@ design/load_store_address_unit.sv @@
// load_store_address_unit: top level, single data transfer execution unit
// depends on lsau_pkg, lsau_front, lsau_queue, lsau_back, lsau_ram
//
//   port group  dir  tdata fields (low bit up)                         tuser
//   s_*         in   instr_word, data_value, reg_index                 req_type
//   m_*         out  mem_address, mem_write_data, byte_access, pc_value result_kind
//
// one item per cycle sustained unless the output stalls; an accepted item passes
// via the queue to the output register (queue pop with register file read, then execute)
// the register file read is registered, the previous write is forwarded
// reset clears control state; never written registers read as zero via valid bits
// a stalled output holds the execute stage; the queue keeps accepting until full
`timescale 1ns / 1ps

module load_store_address_unit #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lsau_pkg::S_TDATA_W-1:0]  s_tdata,  // instr_word, data_value, reg_index
    input  logic [1:0]                      s_tuser,  // req_type
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lsau_pkg::M_TDATA_W-1:0]  m_tdata,  // mem_address, mem_write_data,
                                                      // byte_access, pc_value
    output logic [2:0]                      m_tuser   // result_kind
);

    logic                   full;
    logic                   push;
    lsau_pkg::item_t        push_item;
    logic                   pop;
    logic                   head_valid;
    lsau_pkg::item_t        head_item;
    lsau_pkg::back_status_t status;

    lsau_front u_front (
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .full    (full),
        .push    (push),
        .item    (push_item)
    );

    lsau_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .head_valid(head_valid),
        .head_item (head_item)
    );

    lsau_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_valid(head_valid),
        .head_item (head_item),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .status    (status)
    );

    a_read_sets_pending: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == lsau_pkg::KIND_READ |-> status.load_pending)
        else $error("read request shown without a pending load");

    a_done_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == lsau_pkg::KIND_LOAD_DONE |-> !status.load_pending)
        else $error("load done shown while a load is still pending");

    a_pc_not_in_ram: assert property (@(posedge clk) disable iff (!rst_n)
        status.ram_we |-> status.ram_waddr != lsau_pkg::PC_IDX)
        else $error("register file ram written at the pc index");

    a_no_request_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == lsau_pkg::KIND_IGNORED || m_tuser == lsau_pkg::KIND_LOAD_DONE
                     || m_tuser == lsau_pkg::KIND_REG_WRITTEN) |-> m_tdata[63:0] == '0)
        else $error("address or store data set on a non-request result");

endmodule

@@ dv/load_store_address_unit_test.sv @@
// load_store_address_unit_test: self-checking testbench for the load/store address unit
// keeps its own register file and load tracking to predict every output item
// depends on lsau_pkg and load_store_address_unit
`timescale 1ns / 1ps

module load_store_address_unit_test;

    localparam logic [1:0] REQ_RESERVED = 2'd3;
    localparam int unsigned RANDOM_ITEMS = 1100;
    localparam int unsigned HOLD_START = 400;
    localparam int unsigned HOLD_CYCLES = 120;
    localparam int unsigned SETTLE_CYCLES = 20;

    typedef struct packed {
        logic [1:0]  req;
        logic [31:0] iw;
        logic [31:0] dv;
        logic [3:0]  ri;
    } lsu_item_t;

    typedef struct {
        lsau_pkg::result_kind_t kind;
        logic [31:0]  addr;
        logic [31:0]  wdata;
        logic         bsel;
        logic [31:0]  pc;
    } lsu_result_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [lsau_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic [1:0]                     s_tuser = 2'd0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [lsau_pkg::M_TDATA_W-1:0] m_tdata;
    logic [2:0]                     m_tuser;

    // predicted architectural state
    logic [31:0] gpr [16];
    logic        ld_pending = 1'b0;
    logic [3:0]  ld_target = 4'd0;
    logic        ld_byte = 1'b0;
    logic        ld_dropped = 1'b0;

    lsu_item_t   stim_q [$];
    lsu_result_t expected_q [$];
    lsu_item_t   cur_item;
    lsu_result_t got;

    int errors = 0;
    int pushed_count = 0;
    int in_count = 0;
    int burst_left = 0;
    int gap_left = 0;
    int ready_left = 0;
    int hold_left = 0;
    int cycle_count = 0;
    logic hold_done = 1'b0;

    load_store_address_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        for (int k = 0; k < 16; k++)
            gpr[k] = 32'd0;
    end

    function automatic lsu_result_t execute_item(logic [1:0] req, logic [31:0] iw,
                                                 logic [31:0] dv, logic [3:0] ri);
        lsu_result_t r;
        logic [31:0] off;
        logic [31:0] base;
        logic [31:0] addr;
        logic [31:0] newbase;
        logic [31:0] wdata;
        logic [3:0]  rd;
        logic [3:0]  rn;
        logic        wb;
        r.kind = lsau_pkg::KIND_IGNORED;
        r.addr = 32'd0;
        r.wdata = 32'd0;
        r.bsel = 1'b0;
        rd = iw[15:12];
        rn = iw[19:16];
        case (req)
            lsau_pkg::REQ_INSTR:
            begin
                if (iw[27:26] == lsau_pkg::XFER_OP && !ld_pending)
                begin
                    off = iw[25] ? (gpr[iw[3:0]] << iw[11:7]) : {20'd0, iw[11:0]};
                    base = gpr[rn];
                    newbase = iw[23] ? base + off : base - off;
                    addr = iw[24] ? newbase : base;
                    wb = iw[24] ? iw[21] : 1'b1;
                    if (rn == lsau_pkg::PC_IDX)
                    begin
                        addr = addr + lsau_pkg::PC_AHEAD;
                        newbase = newbase + lsau_pkg::PC_AHEAD;
                    end
                    wdata = iw[22] ? {24'd0, gpr[rd][7:0]} : gpr[rd];
                    if (iw[20])
                    begin
                        ld_pending = 1'b1;
                        ld_target = rd;
                        ld_byte = iw[22];
                        ld_dropped = wb && rn == rd;
                    end
                    if (wb)
                        gpr[rn] = newbase;
                    gpr[lsau_pkg::PC_IDX] = gpr[lsau_pkg::PC_IDX] + lsau_pkg::PC_STEP;
                    r.kind = iw[20] ? lsau_pkg::KIND_READ : lsau_pkg::KIND_WRITE;
                    r.addr = addr;
                    r.wdata = iw[20] ? 32'd0 : wdata;
                    r.bsel = iw[22];
                end
            end
            lsau_pkg::REQ_LOAD_DATA:
            begin
                if (ld_pending)
                begin
                    if (!ld_dropped)
                        gpr[ld_target] = ld_byte ? {24'd0, dv[7:0]} : dv;
                    r.kind = lsau_pkg::KIND_LOAD_DONE;
                    r.bsel = ld_byte;
                    ld_pending = 1'b0;
                    ld_dropped = 1'b0;
                end
            end
            lsau_pkg::REQ_EXT_WRITE:
            begin
                gpr[ri] = dv;
                if (ld_pending && ri == ld_target)
                    ld_dropped = 1'b1;
                r.kind = lsau_pkg::KIND_REG_WRITTEN;
            end
            default:
            begin
            end
        endcase
        r.pc = gpr[lsau_pkg::PC_IDX];
        return r;
    endfunction

    function automatic logic [31:0] xfer_word(logic i, logic p, logic u, logic b, logic w,
                                              logic l, logic [3:0] rn, logic [3:0] rd,
                                              logic [11:0] off);
        return {4'hE, lsau_pkg::XFER_OP, i, p, u, b, w, l, rn, rd, off};
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    task automatic push_item(logic [1:0] req, logic [31:0] iw, logic [31:0] dv,
                             logic [3:0] ri);
        lsu_item_t it;
        it.req = req;
        it.iw = iw;
        it.dv = dv;
        it.ri = ri;
        stim_q.push_back(it);
        pushed_count++;
    endtask

    task automatic wait_all_retired();
        while (in_count != pushed_count || expected_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic add_random(int n);
        int target;
        logic [31:0] iw;
        target = pushed_count + n;
        while (pushed_count < target)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6:
                begin
                    if ($urandom_range(0, 3) == 0)
                        push_item(lsau_pkg::REQ_LOAD_DATA, $urandom, $urandom,
                                  4'($urandom_range(0, 15)));
                    repeat ($urandom_range(0, 2))
                        push_item(lsau_pkg::REQ_EXT_WRITE, $urandom, pick_value(),
                                  4'($urandom_range(0, 15)));
                    iw = $urandom;
                    iw[27:26] = lsau_pkg::XFER_OP;
                    push_item(lsau_pkg::REQ_INSTR, iw, $urandom, 4'($urandom_range(0, 15)));
                    if (iw[20])
                    begin
                        if ($urandom_range(0, 3) == 0)
                            push_item(lsau_pkg::REQ_EXT_WRITE, $urandom, pick_value(),
                                      $urandom_range(0, 1) ? iw[15:12]
                                                           : 4'($urandom_range(0, 15)));
                        if ($urandom_range(0, 5) == 0)
                            push_item(lsau_pkg::REQ_INSTR, $urandom, $urandom,
                                      4'($urandom_range(0, 15)));
                        push_item(lsau_pkg::REQ_LOAD_DATA, $urandom, pick_value(),
                                  4'($urandom_range(0, 15)));
                    end
                end
                7: push_item(lsau_pkg::REQ_INSTR, $urandom, $urandom, 4'($urandom_range(0, 15)));
                8: push_item(lsau_pkg::REQ_LOAD_DATA, $urandom, $urandom,
                             4'($urandom_range(0, 15)));
                default:
                    push_item($urandom_range(0, 1) ? REQ_RESERVED : lsau_pkg::REQ_EXT_WRITE,
                              $urandom, pick_value(), 4'($urandom_range(0, 15)));
            endcase
        end
    endtask

    // sender: bursts and gaps
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= 2'd0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (gap_left > 0)
            begin
                s_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (stim_q.size() > 0)
            begin
                cur_item = stim_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= cur_item.req;
                s_tdata <= {4'd0, cur_item.ri, cur_item.dv, cur_item.iw};
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver: random stall pattern plus one long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            cycle_count <= cycle_count + 1;
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (!hold_done && cycle_count >= HOLD_START)
            begin
                m_tready <= 1'b0;
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end
            else if (ready_left == 0)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    m_tready <= 1'b0;
                    ready_left <= $urandom_range(1, 6);
                end
                else
                begin
                    m_tready <= 1'b1;
                    ready_left <= $urandom_range(1, 40);
                end
            end
            else
                ready_left <= ready_left - 1;
        end
    end

    // accepted input items feed the predictor
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            expected_q.push_back(execute_item(s_tuser, s_tdata[31:0], s_tdata[63:32],
                                              s_tdata[67:64]));
            in_count <= in_count + 1;
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] seen);
        if (want !== seen)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, seen);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected item, expected none, actual kind %0d addr %h",
                         $time, m_tuser, m_tdata[31:0]);
                errors++;
            end
            else
            begin
                got = expected_q.pop_front();
                check_field("result_kind", 32'(got.kind), 32'(m_tuser));
                check_field("mem_address", got.addr, m_tdata[31:0]);
                check_field("mem_write_data", got.wdata, m_tdata[63:32]);
                check_field("byte_access", 32'(got.bsel), 32'(m_tdata[64]));
                check_field("pc_value", got.pc, m_tdata[96:65]);
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: register setup, ignored items, immediate and register offset addressing forms
        push_item(lsau_pkg::REQ_EXT_WRITE, 32'd0, 32'h1000_0000, 4'd1);
        push_item(lsau_pkg::REQ_EXT_WRITE, 32'd0, 32'hFFFF_FFFF, 4'd2);
        push_item(lsau_pkg::REQ_EXT_WRITE, 32'd0, 32'h0000_0003, 4'd3);
        push_item(lsau_pkg::REQ_INSTR, 32'hFFFF_FFFF, 32'd0, 4'd0);
        push_item(lsau_pkg::REQ_LOAD_DATA, 32'd0, 32'h1234_5678, 4'd0);
        push_item(REQ_RESERVED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF);
        push_item(lsau_pkg::REQ_INSTR,
                  xfer_word(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 4'd1, 4'd2, 12'hFFF),
                  32'd0, 4'd0);
        push_item(lsau_pkg::REQ_INSTR,
                  xfer_word(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 4'd1, 4'd2, 12'h010),
                  32'd0, 4'd0);
        push_item(lsau_pkg::REQ_INSTR,
                  xfer_word(1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 4'd1, 4'd4, 12'h004),
                  32'd0, 4'd0);
        push_item(lsau_pkg::REQ_INSTR,
                  xfer_word(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 4'd3, 4'd3, 12'h000),
                  32'd0, 4'd0);
        push_item(lsau_pkg::REQ_LOAD_DATA, 32'd0, 32'hDEAD_BEEF, 4'd0);
        push_item(lsau_pkg::REQ_INSTR,
                  xfer_word(1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 4'd1, 4'd5,
                            {5'd31, 3'd0, 4'd3}),
                  32'd0, 4'd0);
        push_item(lsau_pkg::REQ_EXT_WRITE, 32'd0, 32'h1234_5678, 4'd5);
        push_item(lsau_pkg::REQ_LOAD_DATA, 32'd0, 32'hFFFF_FFFF, 4'd0);
        push_item(lsau_pkg::REQ_INSTR,
                  xfer_word(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 4'd6, 4'd6, 12'h008),
                  32'd0, 4'd0);
        push_item(lsau_pkg::REQ_LOAD_DATA, 32'd0, 32'hA5A5_A5A5, 4'd0);
        push_item(lsau_pkg::REQ_INSTR,
                  xfer_word(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, lsau_pkg::PC_IDX, 4'd1,
                            12'h000),
                  32'd0, 4'd0);
        push_item(lsau_pkg::REQ_INSTR,
                  xfer_word(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, lsau_pkg::PC_IDX, 4'd7,
                            12'h020),
                  32'd0, 4'd0);
        push_item(lsau_pkg::REQ_LOAD_DATA, 32'd0, 32'h0000_0080, 4'd0);
        push_item(lsau_pkg::REQ_INSTR,
                  xfer_word(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 4'd3, lsau_pkg::PC_IDX,
                            {5'd0, 3'd0, lsau_pkg::PC_IDX}),
                  32'd0, 4'd0);
        push_item(lsau_pkg::REQ_INSTR,
                  xfer_word(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 4'd0, lsau_pkg::PC_IDX,
                            12'h000),
                  32'd0, 4'd0);
        push_item(lsau_pkg::REQ_LOAD_DATA, 32'd0, 32'h0000_0100, 4'd0);
        push_item(lsau_pkg::REQ_EXT_WRITE, 32'd0, 32'hFFFF_FFF0, lsau_pkg::PC_IDX);
        push_item(lsau_pkg::REQ_EXT_WRITE, 32'd0, 32'd0, 4'd0);
        push_item(lsau_pkg::REQ_INSTR,
                  xfer_word(1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 4'd2, 4'd2, 12'hFFF),
                  32'd0, 4'd0);
        wait_all_retired();

        add_random(RANDOM_ITEMS / 2);
        wait_all_retired();
        add_random(RANDOM_ITEMS / 2);
        wait_all_retired();

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
